[rtl/sgr_pkg.sv]
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;

    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int GRAD_W      = 11;
    localparam int MAG_W       = 8;
    localparam int SQ_W        = 21;
    localparam int COL_W       = ADDR_W;
    localparam int WID_W       = 11;
    localparam int ROW_W       = 13;
    localparam int OUT_ROW_W   = 12;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

[rtl/sgr_line_mem.sv]
`timescale 1ns / 1ps

// Both line buffers share one word: the upper byte is the row two above,
// the lower byte the row directly above.
module sgr_line_mem
    import sgr_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] mem [0:MAX_WIDTH-1];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sgr_isqrt.sv]
`timescale 1ns / 1ps

// Integer square root, one result bit per cycle from the top down.
// Values of 65536 and above saturate at 255.
module sgr_isqrt
    import sgr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQ_W-1:0]  value,
    output root_stat_t       stat,
    output logic [MAG_W-1:0] root
);

    localparam int STEP_W = $clog2(MAG_W);
    localparam int VAL_W  = 2 * MAG_W;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              sat_reg;

    logic [MAG_W-1:0]  trial;
    logic [VAL_W-1:0]  trial_sq;

    assign trial    = root_reg | (MAG_W'(1) << step_reg);
    assign trial_sq = trial * trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(MAG_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            root_reg <= '0;
            val_reg  <= value[VAL_W-1:0];
            sat_reg  <= |value[SQ_W-1:VAL_W];
        end
        else if (busy_reg && (trial_sq <= val_reg))
        begin
            root_reg <= trial;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = sat_reg ? {MAG_W{1'b1}} : root_reg;

endmodule

[rtl/sobel_gradient_3x3_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: pixel; s_tuser: kind (1 = drain)
// m_*       out  m_tvalid/m_tready    m_tdata: grad_x, grad_y, magnitude; m_tlast
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 width, 1 height)
//
// A pixel goes through the line buffer read and the window shift and write-back;
// one that yields a result goes on through gradients, squares, sum, eight square-root
// steps and the output load. A flushing drain skips the shift; an ignored one is only accepted.
// Reset clears the window and position counters; the 1024 x 16 line memory is not.
// A stalled result sits in the output register while the next item is taken; a
// later result waits in the root stage until the output register drains.
module sobel_gradient_3x3_top
    import sgr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] pixel
    input  logic [0:0]             s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [10:0] grad_x, [21:11] grad_y,
                                              // [29:22] magnitude, [31:30] zero
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_GRAD  = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [WID_W-1:0]     eff_w_reg;
    logic [ROW_W-1:0]     eff_h_reg;
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic [PIX_W-1:0]     window_reg [0:8];
    logic [PIX_W-1:0]     pix_reg;
    logic                 emit_after_reg;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                     last_reg;
    logic [SQ_W-2:0]          sqx_reg, sqy_reg;

    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 s_acc;
    logic                 is_pix;
    logic                 frame_done;
    logic                 cfg_wr;
    logic                 out_free;
    logic                 out_load;
    logic                 root_start;

    logic [LINE_W-1:0]    mem_rd_data;
    logic [LINE_W-1:0]    mem_wr_data;
    logic                 mem_rd_en;
    logic                 mem_wr_en;

    root_stat_t           root_stat;
    logic [MAG_W-1:0]     root;

    logic [WID_W-1:0]     w_m1;
    logic [ROW_W-1:0]     h_m1;
    logic                 out_col_end;
    logic                 out_row_end;
    logic                 border;
    logic                 last_pos;

    logic [PIX_W+1:0]     pos_x, neg_x, pos_y, neg_y;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [WID_W-1:0]     cfg_w_clamp;
    logic [ROW_W-1:0]     cfg_h_clamp;

    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign s_acc      = s_tvalid && s_tready;
    assign frame_done = (in_row_reg >= eff_h_reg);
    assign is_pix     = !s_tuser[0] && !frame_done;
    assign cfg_wr     = cfg_valid && cfg_ready
                        && ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == S_ROOT) && root_stat.done && out_free;
    assign root_start = (state_reg == S_SUM);

    // Clamp the written value into the supported range.
    always_comb
    begin
        cfg_w_clamp = cfg_data[WID_W-1:0];
        if (cfg_w_clamp == '0)
        begin
            cfg_w_clamp = WID_W'(1);
        end
        else if (cfg_w_clamp > WID_W'(MAX_WIDTH))
        begin
            cfg_w_clamp = WID_W'(MAX_WIDTH);
        end
        cfg_h_clamp = cfg_data[ROW_W-1:0];
        if (cfg_h_clamp == '0)
        begin
            cfg_h_clamp = ROW_W'(1);
        end
        else if (cfg_h_clamp > ROW_W'(MAX_HEIGHT))
        begin
            cfg_h_clamp = ROW_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= WID_W'(640);
            eff_h_reg <= ROW_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                eff_w_reg <= cfg_w_clamp;
            end
            else if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                eff_h_reg <= cfg_h_clamp;
            end
        end
    end

    assign w_m1        = eff_w_reg - WID_W'(1);
    assign h_m1        = eff_h_reg - ROW_W'(1);
    assign out_col_end = ({1'b0, out_col_reg} == w_m1);
    assign out_row_end = ({1'b0, out_row_reg} == h_m1);
    assign last_pos    = out_col_end && out_row_end;
    assign border      = (out_col_reg == '0) || out_col_end
                         || (out_row_reg == '0) || out_row_end;

    always_comb
    begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (is_pix)
                    begin
                        state_next = S_SHIFT;
                    end
                    else if (frame_done)
                    begin
                        state_next = S_GRAD;
                    end
                end
            end
            S_SHIFT:
            begin
                if (({1'b0, in_col_reg} + WID_W'(1)) >= eff_w_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                state_next = emit_after_reg ? S_GRAD : S_IDLE;
            end
            S_GRAD:
            begin
                // The final position of the frame restarts all counters.
                if (last_pos)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // The first width+1 pixels of a frame fill the window and give no result.
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            pix_reg        <= s_tdata[PIX_W-1:0];
            emit_after_reg <= !((in_row_reg == '0)
                                || ((in_row_reg == ROW_W'(1)) && (in_col_reg == '0)));
        end
    end

    // The read is issued at acceptance and written back in the following cycle, so
    // the next read of the same column always sees the updated word.
    assign mem_rd_en   = s_acc && is_pix;
    assign mem_wr_en   = (state_reg == S_SHIFT);
    assign mem_wr_data = {mem_rd_data[PIX_W-1:0], pix_reg};

    sgr_line_mem u_line_mem
    (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (in_col_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (in_col_reg),
        .wr_data (mem_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (state_reg == S_SHIFT)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= mem_rd_data[LINE_W-1:PIX_W];
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= mem_rd_data[PIX_W-1:0];
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= pix_reg;
        end
    end

    assign pos_x = {2'b00, window_reg[2]} + {1'b0, window_reg[5], 1'b0} + {2'b00, window_reg[8]};
    assign neg_x = {2'b00, window_reg[0]} + {1'b0, window_reg[3], 1'b0} + {2'b00, window_reg[6]};
    assign pos_y = {2'b00, window_reg[6]} + {1'b0, window_reg[7], 1'b0} + {2'b00, window_reg[8]};
    assign neg_y = {2'b00, window_reg[0]} + {1'b0, window_reg[1], 1'b0} + {2'b00, window_reg[2]};

    assign prod_x = gx_reg * gx_reg;
    assign prod_y = gy_reg * gy_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GRAD)
        begin
            last_reg <= last_pos;
            if (border)
            begin
                gx_reg <= '0;
                gy_reg <= '0;
            end
            else
            begin
                gx_reg <= $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
                gy_reg <= $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
            end
        end
        if (state_reg == S_SQ)
        begin
            sqx_reg <= prod_x[SQ_W-2:0];
            sqy_reg <= prod_y[SQ_W-2:0];
        end
    end

    sgr_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value ({1'b0, sqx_reg} + {1'b0, sqy_reg}),
        .stat  (root_stat),
        .root  (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {2'b00, root, gy_reg, gx_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transaction");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, in_col_reg} < eff_w_reg))
        else $error("input column beyond frame width");

    a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, out_col_reg} < eff_w_reg) && ({1'b0, out_row_reg} < eff_h_reg))
        else $error("output position beyond frame");

    a_pixel_shift: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> (state_reg == S_SHIFT) && mem_wr_en)
        else $error("line buffer read not followed by write-back");

    a_root_start: assert property (@(posedge clk) disable iff (!rst_n)
        root_start |=> root_stat.busy && !root_stat.done && (state_reg == S_ROOT))
        else $error("square root unit did not start");
`endif

endmodule

[verif/sobel_gradient_3x3_top_test.sv]
`timescale 1ns / 1ps

module sobel_gradient_3x3_top_test;
    import sgr_pkg::*;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } item_kind_t;

    typedef enum int
    {
        STYLE_PLAIN,
        STYLE_EARLY,
        STYLE_SURPLUS,
        STYLE_CUT
    } frame_style_t;

    typedef struct packed
    {
        item_kind_t       kind;
        logic [PIX_W-1:0] pixel;
    } stream_item_t;

    typedef struct
    {
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]  magnitude;
        logic              last;
    } gradient_t;

    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_STALL    = 400;
    localparam int RANDOM_ITEMS  = 800;
    localparam int TIMEOUT_NS    = 3_000_000;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    stream_item_t pending_items[$];
    gradient_t    expected_grads[$];

    int in_idle_pct;
    int out_idle_pct;
    bit in_taken;
    int cfg_accepts;
    int stall_requests;
    int stall_seen;
    int stall_left;
    int error_count;
    int items_taken;
    int grads_checked;
    int frames_sent;
    int items_queued;

    // Register values as last written by the stimulus, used to size frames.
    logic [WID_W-1:0] cfg_width_val  = 11'd640;
    logic [ROW_W-1:0] cfg_height_val = 13'd480;

    // Predictor state.
    logic [WID_W-1:0] width_reg  = 11'd640;
    logic [ROW_W-1:0] height_reg = 13'd480;
    logic [PIX_W-1:0] row_above     [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0] row_two_above [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0] win [9] = '{default: '0};
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;

    sobel_gradient_3x3_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("sobel_gradient_3x3_top: mismatch");
        $finish;
    end

    function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned limit);
        if (value < 1)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [MAG_W-1:0] root_sat(input int unsigned sq);
        int unsigned root = 0;
        int unsigned trial;
        if (sq >= 65536)
            return 8'd255;
        for (int b = 7; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[MAG_W-1:0];
    endfunction

    function automatic void clear_positions();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic gradient_t next_gradient(input int unsigned w, input int unsigned h);
        gradient_t g;
        int        gx;
        int        gy;
        bit        at_end;
        gx     = 0;
        gy     = 0;
        at_end = (out_row == h - 1) && (out_col == w - 1);
        if (out_col != 0 && out_col != w - 1 && out_row != 0 && out_row != h - 1)
        begin
            gx = int'(win[2]) - int'(win[0]) + 2 * (int'(win[5]) - int'(win[3]))
                 + int'(win[8]) - int'(win[6]);
            gy = int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
                 - int'(win[0]) - 2 * int'(win[1]) - int'(win[2]);
        end
        g.grad_x    = gx[GRAD_W-1:0];
        g.grad_y    = gy[GRAD_W-1:0];
        g.magnitude = root_sat(gx * gx + gy * gy);
        g.last      = at_end;
        if (at_end)
            clear_positions();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return g;
    endfunction

    // Returns 1 when the accepted item brings out a result.
    function automatic bit predict_item(input stream_item_t item, output gradient_t g);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        longint unsigned  pos;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (item.kind == KIND_PIXEL && in_row < h)
        begin
            col    = in_col % MAX_WIDTH;
            pos    = longint'(in_row) * w + in_col;
            top    = row_two_above[col];
            mid    = row_above[col];
            win[0] = win[1];
            win[1] = win[2];
            win[2] = top;
            win[3] = win[4];
            win[4] = win[5];
            win[5] = mid;
            win[6] = win[7];
            win[7] = win[8];
            win[8] = item.pixel;
            row_two_above[col] = mid;
            row_above[col]     = item.pixel;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (pos < w + 1)
                return 1'b0;
            g = next_gradient(w, h);
            return 1'b1;
        end
        // Early drains are dropped; anything after the last pixel flushes the tail.
        if (in_row < h)
            return 1'b0;
        g = next_gradient(w, h);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [GRAD_W-1:0] want,
                                        input logic [GRAD_W-1:0] got, input bit is_signed);
        if (got !== want)
        begin
            error_count++;
            if (is_signed)
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            else
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_width();
        case ($urandom_range(11))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(40, 13));
            default: return CFG_DATA_W'($urandom_range(12, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_height();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(10, 7));
            default: return CFG_DATA_W'($urandom_range(6, 1));
        endcase
    endfunction

    // Checks results, applies register writes and predicts every accepted item.
    always @(posedge clk)
    begin : monitor
        gradient_t    seen;
        gradient_t    want;
        gradient_t    fresh;
        stream_item_t took;
        in_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.grad_x    = m_tdata[10:0];
                seen.grad_y    = m_tdata[21:11];
                seen.magnitude = m_tdata[29:22];
                seen.last      = m_tlast;
                grads_checked++;
                if (expected_grads.size() == 0)
                begin
                    error_count++;
                    $error("grad_x: no result expected, actual %0d", $signed(seen.grad_x));
                end
                else
                begin
                    want = expected_grads.pop_front();
                    check_field("grad_x", want.grad_x, seen.grad_x, 1'b1);
                    check_field("grad_y", want.grad_y, seen.grad_y, 1'b1);
                    check_field("magnitude", GRAD_W'(want.magnitude),
                                GRAD_W'(seen.magnitude), 1'b0);
                    check_field("last", GRAD_W'(want.last), GRAD_W'(seen.last), 1'b0);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_accepts++;
                if (cfg_index == CFG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data[WID_W-1:0];
                    clear_positions();
                end
                else if (cfg_index == CFG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_data[ROW_W-1:0];
                    clear_positions();
                end
            end
            if (in_taken)
            begin
                items_taken++;
                took.kind  = item_kind_t'(s_tuser[0]);
                took.pixel = s_tdata;
                if (predict_item(took, fresh))
                    expected_grads.push_back(fresh);
            end
        end
    end

    always @(negedge clk)
    begin : driver
        stream_item_t next_item;
        if (!s_tvalid || in_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.pixel;
                s_tuser  <= next_item.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // A new stall request holds the output off until its stall count runs out.
    always @(negedge clk)
    begin : receiver
        if (stall_requests != stall_seen)
        begin
            stall_seen = stall_requests;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic push_item(input item_kind_t kind, input logic [PIX_W-1:0] pixel);
        stream_item_t item;
        item.kind  = kind;
        item.pixel = pixel;
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        int accepts_at_start;
        accepts_at_start = cfg_accepts;
        if (index == CFG_FRAME_WIDTH)
            cfg_width_val = value[WID_W-1:0];
        else
            cfg_height_val = value[ROW_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        while (cfg_accepts == accepts_at_start)
            @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every item is accepted and every result has arrived, then lets
    // the pipeline settle so that items without a result are finished too.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_grads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_frame(input frame_style_t style);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned cut;
        w     = clamp_dim(cfg_width_val, MAX_WIDTH);
        h     = clamp_dim(cfg_height_val, MAX_HEIGHT);
        total = w * h;
        cut   = (style == STYLE_CUT) ? $urandom_range(total - 1, 0) : total;
        for (int unsigned i = 0; i < cut; i++)
        begin
            if (style == STYLE_EARLY && $urandom_range(7) == 0)
                push_item(KIND_DRAIN, rand_pixel());
            push_item(KIND_PIXEL, rand_pixel());
        end
        if (style != STYLE_CUT)
        begin
            for (int unsigned i = 0; i <= w; i++)
                push_item((style == STYLE_SURPLUS) ? KIND_PIXEL : KIND_DRAIN, rand_pixel());
            if ($urandom_range(3) == 0)
                push_item(KIND_DRAIN, rand_pixel());
        end
        frames_sent++;
    endtask

    initial
    begin : main
        logic [PIX_W-1:0] edge_x [9];
        logic [PIX_W-1:0] edge_y [9];
        logic [PIX_W-1:0] tail_px [4];
        frame_style_t     style;
        bit               restart;
        edge_x  = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
        edge_y  = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        tail_px = '{8'hFF, 8'h00, 8'h80, 8'h7F};
        in_idle_pct  = 18;
        out_idle_pct = 47;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An oversized width clamps to the widest row; the frame is cut short.
        write_reg(CFG_FRAME_WIDTH, 13'd2047);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        repeat (8) push_item(KIND_PIXEL, rand_pixel());
        wait_drained();

        // Zero registers clamp to a single pixel; the frame closes on a surplus pixel.
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        push_item(KIND_DRAIN, 8'h00);
        push_item(KIND_PIXEL, 8'hA5);
        push_item(KIND_PIXEL, 8'h5A);
        push_item(KIND_DRAIN, 8'hFF);
        wait_drained();

        // Bits above the width register are dropped, leaving a 3x3 frame.
        write_reg(CFG_FRAME_WIDTH, 13'h1803);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                push_item(KIND_DRAIN, 8'h3C);
            push_item(KIND_PIXEL, edge_x[i]);
        end
        repeat (5) push_item(KIND_DRAIN, 8'hC3);
        wait_drained();
        for (int i = 0; i < 9; i++)
            push_item(KIND_PIXEL, edge_y[i]);
        for (int i = 0; i < 4; i++)
            push_item(KIND_PIXEL, tail_px[i]);
        wait_drained();

        // Tallest height, cut short and restarted by the next register write.
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        repeat (10) push_item(KIND_PIXEL, rand_pixel());
        restart = 1'b1;

        items_queued = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            in_idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 47 : 0;
            out_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 18 : 0;
            if (phase == 2)
            begin
                // The output is held off while the sender keeps offering transactions.
                write_reg(CFG_FRAME_WIDTH, 13'd32);
                write_reg(CFG_FRAME_HEIGHT, 13'd6);
                push_frame(STYLE_PLAIN);
                stall_requests++;
                wait_drained();
                restart = 1'b0;
            end
            while (items_queued < RANDOM_ITEMS * (phase + 1) / 3)
            begin
                if (restart || $urandom_range(2) == 0)
                begin
                    wait_drained();
                    case ($urandom_range(3))
                        0: write_reg(CFG_FRAME_WIDTH, rand_width());
                        1: write_reg(CFG_FRAME_HEIGHT, rand_height());
                        default:
                        begin
                            write_reg(CFG_FRAME_WIDTH, rand_width());
                            write_reg(CFG_FRAME_HEIGHT, rand_height());
                        end
                    endcase
                end
                if ($urandom_range(9) < 6)
                    style = STYLE_PLAIN;
                else
                    style = frame_style_t'($urandom_range(STYLE_CUT, STYLE_EARLY));
                push_frame(style);
                restart = (style == STYLE_CUT);
            end
        end
        wait_drained();

        $display("Sent %0d frames as %0d input transactions under two idle mixes and none,",
                 frames_sent, items_taken);
        $display("with a long output stall; %0d result transactions were checked.", grads_checked);
        if (error_count == 0)
            $display("sobel_gradient_3x3_top: match");
        else
            $display("sobel_gradient_3x3_top: mismatch");
        $finish;
    end

endmodule
